// File: rtl/core/cmam_pkg.sv
`timescale 1ns / 1ps

package cmam_pkg;

  localparam int Entries     = 32;
  localparam int MatchBits   = 32;
  localparam int MinuteBits  = 60;
  localparam int HourBits    = 24;
  localparam int DayBits     = 32;
  localparam int MonthBits   = 13;
  localparam int WeekdayBits = 7;

  localparam logic [5:0]  LastMinute   = 6'd59;
  localparam logic [4:0]  LastHour     = 5'd23;
  localparam logic [3:0]  LastMonth    = 4'd12;
  localparam logic [2:0]  DaysPerWeek  = 3'd7;
  localparam logic [4:0]  LongMonth    = 5'd31;
  localparam logic [4:0]  LeapFebDays  = 5'd29;
  localparam logic [3:0]  February     = 4'd2;

  localparam logic [13:0] ResetYear    = 14'd1970;
  localparam logic [3:0]  ResetMonth   = 4'd1;
  localparam logic [4:0]  ResetDay     = 5'd1;
  localparam logic [2:0]  ResetWeekday = 3'd4;

  // Multiplicative inverse of 25 modulo 2**14. A 14-bit year is a multiple of 25
  // exactly when its product with the inverse, taken modulo 2**14, is at most 655.
  localparam logic [13:0] Inv25      = 14'd7209;
  localparam logic [13:0] Div25Limit = 14'd655;

  localparam logic [4:0] MonthDays [13] = '{
    5'd0, 5'd31, 5'd28, 5'd31, 5'd30, 5'd31, 5'd30,
    5'd31, 5'd31, 5'd30, 5'd31, 5'd30, 5'd31
  };

  typedef enum logic [1:0] {
    ModeSetMask   = 2'd0,
    ModeLoadClock = 2'd1,
    ModeTick      = 2'd2
  } mode_e;

  typedef enum logic [2:0] {
    FieldMinute  = 3'd0,
    FieldHour    = 3'd1,
    FieldDay     = 3'd2,
    FieldMonth   = 3'd3,
    FieldWeekday = 3'd4
  } field_e;

  // Gregorian rule: divisible by 4, and by 16 as well when divisible by 25.
  function automatic logic is_leap(logic [13:0] year);
    logic [27:0] prod;
    logic        div25;
    prod  = 28'(year) * 28'(Inv25);
    div25 = (prod[13:0] <= Div25Limit);
    return (year[1:0] == 2'b00) && (!div25 || (year[3:0] == 4'b0000));
  endfunction

  function automatic logic [4:0] days_in_month(logic [13:0] year, logic [3:0] month);
    logic [4:0] days;
    if ((month == February) && is_leap(year)) begin
      days = LeapFebDays;
    end else if ((month >= 4'd1) && (month <= LastMonth)) begin
      days = MonthDays[month];
    end else begin
      days = LongMonth;
    end
    return days;
  endfunction

endpackage

// File: rtl/core/cron_minute_alarm_matcher_top.sv
`timescale 1ns / 1ps

// Channel | Direction | Handshake                | Payload
// input   | in        | in_valid_i / in_stall_o  | mode, entry/field/range, clock load values
// result  | out       | out_valid_o / out_stall_i| current time and match_mask (ticks only)
//
// An item is taken into an input register, and its work is done between that
// register and the result register, so a tick result is registered in the result
// register as it leaves the input register. One item can be accepted every cycle while in_stall_o is low.
// in_stall_o is raised only while a tick waits behind a stalled, undelivered result.
// Reset clears all masks and sets the clock to 1970-01-01 00:00, a Thursday.
module cron_minute_alarm_matcher_top import cmam_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,

  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  mode_i,
  input  logic [4:0]  entry_index_i,
  input  logic [2:0]  field_select_i,
  input  logic [5:0]  range_low_i,
  input  logic [5:0]  range_high_i,
  input  logic [13:0] set_year_i,
  input  logic [3:0]  set_month_i,
  input  logic [4:0]  set_day_i,
  input  logic [4:0]  set_hour_i,
  input  logic [5:0]  set_minute_i,
  input  logic [2:0]  set_weekday_i,

  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [13:0] now_year_o,
  output logic [3:0]  now_month_o,
  output logic [4:0]  now_day_o,
  output logic [4:0]  now_hour_o,
  output logic [5:0]  now_minute_o,
  output logic [2:0]  now_weekday_o,
  output logic [31:0] match_mask_o
);

  // Input register
  logic        s1_valid_q;
  logic [1:0]  s1_mode_q;
  logic [4:0]  s1_entry_index_q;
  logic [2:0]  s1_field_select_q;
  logic [5:0]  s1_range_low_q;
  logic [5:0]  s1_range_high_q;
  logic [13:0] s1_year_q;
  logic [3:0]  s1_month_q;
  logic [4:0]  s1_day_q;
  logic [4:0]  s1_hour_q;
  logic [5:0]  s1_minute_q;
  logic [2:0]  s1_weekday_q;

  // Calendar clock
  logic [13:0] clock_year_q, clock_year_d;
  logic [3:0]  clock_month_q, clock_month_d;
  logic [4:0]  clock_day_q, clock_day_d;
  logic [4:0]  clock_hour_q, clock_hour_d;
  logic [5:0]  clock_minute_q, clock_minute_d;
  logic [2:0]  clock_weekday_q, clock_weekday_d;

  // Alarm masks
  logic [MinuteBits-1:0]  minute_masks_q  [Entries];
  logic [HourBits-1:0]    hour_masks_q    [Entries];
  logic [DayBits-1:0]     day_masks_q     [Entries];
  logic [MonthBits-1:0]   month_masks_q   [Entries];
  logic [WeekdayBits-1:0] weekday_masks_q [Entries];

  // Result register
  logic        out_valid_q;
  logic [13:0] now_year_q;
  logic [3:0]  now_month_q;
  logic [4:0]  now_day_q;
  logic [4:0]  now_hour_q;
  logic [5:0]  now_minute_q;
  logic [2:0]  now_weekday_q;
  logic [31:0] match_mask_q;

  logic                   in_accept;
  logic                   out_free;
  logic                   s1_is_tick;
  logic                   s1_fire;
  logic                   mask_write;
  logic [MinuteBits-1:0]  range_bits;
  logic [MinuteBits-1:0]  minute_sel;
  logic [HourBits-1:0]    hour_sel;
  logic [DayBits-1:0]     day_sel;
  logic [MonthBits-1:0]   month_sel;
  logic [WeekdayBits-1:0] weekday_sel;
  logic [MatchBits-1:0]   match_d;
  logic [3:0]             weekday_inc;

  assign out_free   = !out_valid_q || !out_stall_i;
  assign s1_is_tick = (s1_mode_q == ModeTick);
  assign s1_fire    = s1_valid_q && (!s1_is_tick || out_free);
  assign in_stall_o = s1_valid_q && !s1_fire;
  assign in_accept  = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_accept) begin
      s1_valid_q <= 1'b1;
    end else if (s1_fire) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      s1_mode_q         <= mode_i;
      s1_entry_index_q  <= entry_index_i;
      s1_field_select_q <= field_select_i;
      s1_range_low_q    <= range_low_i;
      s1_range_high_q   <= range_high_i;
      s1_year_q         <= set_year_i;
      s1_month_q        <= set_month_i;
      s1_day_q          <= set_day_i;
      s1_hour_q         <= set_hour_i;
      s1_minute_q       <= set_minute_i;
      s1_weekday_q      <= set_weekday_i;
    end
  end

  // Bits past a mask's size fall away when the range is truncated to that mask.
  always_comb begin
    for (int i = 0; i < MinuteBits; i++) begin
      range_bits[i] = (i >= int'(s1_range_low_q)) && (i <= int'(s1_range_high_q));
    end
  end

  assign mask_write = s1_fire && (s1_mode_q == ModeSetMask);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      minute_masks_q  <= '{default: '0};
      hour_masks_q    <= '{default: '0};
      day_masks_q     <= '{default: '0};
      month_masks_q   <= '{default: '0};
      weekday_masks_q <= '{default: '0};
    end else if (mask_write) begin
      for (int e = 0; e < Entries; e++) begin
        if (int'(s1_entry_index_q) == e) begin
          case (s1_field_select_q)
            FieldMinute: begin
              minute_masks_q[e] <= minute_masks_q[e] | range_bits;
            end
            FieldHour: begin
              hour_masks_q[e] <= hour_masks_q[e] | range_bits[HourBits-1:0];
            end
            FieldDay: begin
              day_masks_q[e] <= day_masks_q[e] | range_bits[DayBits-1:0];
            end
            FieldMonth: begin
              month_masks_q[e] <= month_masks_q[e] | range_bits[MonthBits-1:0];
            end
            FieldWeekday: begin
              weekday_masks_q[e] <= weekday_masks_q[e] | range_bits[WeekdayBits-1:0];
            end
            default: begin
            end
          endcase
        end
      end
    end
  end

  // One-hot selects of the current time; a value past a mask's size selects nothing.
  assign minute_sel  = {{(MinuteBits-1){1'b0}}, 1'b1} << clock_minute_q;
  assign hour_sel    = {{(HourBits-1){1'b0}}, 1'b1} << clock_hour_q;
  assign day_sel     = {{(DayBits-1){1'b0}}, 1'b1} << clock_day_q;
  assign month_sel   = {{(MonthBits-1){1'b0}}, 1'b1} << clock_month_q;
  assign weekday_sel = {{(WeekdayBits-1){1'b0}}, 1'b1} << clock_weekday_q;

  always_comb begin
    match_d = '0;
    for (int e = 0; e < MatchBits; e++) begin
      if (e < Entries) begin
        match_d[e] = (|(minute_masks_q[e] & minute_sel)) &&
                     (|(hour_masks_q[e] & hour_sel)) &&
                     (|(day_masks_q[e] & day_sel)) &&
                     (|(month_masks_q[e] & month_sel)) &&
                     (|(weekday_masks_q[e] & weekday_sel));
      end
    end
  end

  assign weekday_inc = {1'b0, clock_weekday_q} + 4'd1;

  always_comb begin
    clock_year_d    = clock_year_q;
    clock_month_d   = clock_month_q;
    clock_day_d     = clock_day_q;
    clock_hour_d    = clock_hour_q;
    clock_minute_d  = clock_minute_q;
    clock_weekday_d = clock_weekday_q;
    if (s1_fire && (s1_mode_q == ModeLoadClock)) begin
      clock_year_d    = s1_year_q;
      clock_month_d   = s1_month_q;
      clock_day_d     = s1_day_q;
      clock_hour_d    = s1_hour_q;
      clock_minute_d  = s1_minute_q;
      clock_weekday_d = s1_weekday_q;
    end else if (s1_fire && s1_is_tick) begin
      // Out-of-range minute and hour values act as the last one and carry.
      if (clock_minute_q < LastMinute) begin
        clock_minute_d = clock_minute_q + 6'd1;
      end else begin
        clock_minute_d = '0;
        if (clock_hour_q < LastHour) begin
          clock_hour_d = clock_hour_q + 5'd1;
        end else begin
          clock_hour_d    = '0;
          clock_weekday_d = (weekday_inc >= {1'b0, DaysPerWeek}) ?
                            3'(weekday_inc - {1'b0, DaysPerWeek}) : weekday_inc[2:0];
          if (clock_day_q < days_in_month(clock_year_q, clock_month_q)) begin
            clock_day_d = clock_day_q + 5'd1;
          end else begin
            clock_day_d = ResetDay;
            if (clock_month_q < LastMonth) begin
              clock_month_d = clock_month_q + 4'd1;
            end else begin
              clock_month_d = ResetMonth;
              clock_year_d  = clock_year_q + 14'd1;
            end
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clock_year_q    <= ResetYear;
      clock_month_q   <= ResetMonth;
      clock_day_q     <= ResetDay;
      clock_hour_q    <= '0;
      clock_minute_q  <= '0;
      clock_weekday_q <= ResetWeekday;
    end else begin
      clock_year_q    <= clock_year_d;
      clock_month_q   <= clock_month_d;
      clock_day_q     <= clock_day_d;
      clock_hour_q    <= clock_hour_d;
      clock_minute_q  <= clock_minute_d;
      clock_weekday_q <= clock_weekday_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q <= s1_fire && s1_is_tick;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_fire && s1_is_tick) begin
      now_year_q    <= clock_year_q;
      now_month_q   <= clock_month_q;
      now_day_q     <= clock_day_q;
      now_hour_q    <= clock_hour_q;
      now_minute_q  <= clock_minute_q;
      now_weekday_q <= clock_weekday_q;
      match_mask_q  <= match_d;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign now_year_o    = now_year_q;
  assign now_month_o   = now_month_q;
  assign now_day_o     = now_day_q;
  assign now_hour_o    = now_hour_q;
  assign now_minute_o  = now_minute_q;
  assign now_weekday_o = now_weekday_q;
  assign match_mask_o  = match_mask_q;

endmodule

// File: rtl/core/cmam_checker.sv
`timescale 1ns / 1ps

module cmam_checker import cmam_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_stall_o,
  input  logic [1:0]  mode_i,
  input  logic [13:0] set_year_i,
  input  logic [3:0]  set_month_i,
  input  logic [4:0]  set_day_i,
  input  logic [4:0]  set_hour_i,
  input  logic [5:0]  set_minute_i,
  input  logic [2:0]  set_weekday_i,
  input  logic        out_valid_o,
  input  logic        out_stall_i,
  input  logic [13:0] now_year_o,
  input  logic [3:0]  now_month_o,
  input  logic [4:0]  now_day_o,
  input  logic [4:0]  now_hour_o,
  input  logic [5:0]  now_minute_o,
  input  logic [2:0]  now_weekday_o,
  input  logic [31:0] match_mask_o
);

  // The input side only ever waits on a result that the output side is holding back.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (out_valid_o && out_stall_i))
    else $error("input stalled while the result side was free");

  // A tick right behind a clock load reports exactly the loaded time.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o && (mode_i == ModeLoadClock)) ##1
    (in_valid_i && !in_stall_o && (mode_i == ModeTick)) ##1
    (!out_valid_o || !out_stall_i)
    |=> out_valid_o &&
        (now_year_o == $past(set_year_i, 3)) &&
        (now_month_o == $past(set_month_i, 3)) &&
        (now_day_o == $past(set_day_i, 3)) &&
        (now_hour_o == $past(set_hour_i, 3)) &&
        (now_minute_o == $past(set_minute_i, 3)) &&
        (now_weekday_o == $past(set_weekday_i, 3)))
    else $error("tick after clock load did not report the loaded time");

  // A stalled result stays put.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=>
    out_valid_o && $stable(match_mask_o) && $stable(now_minute_o) && $stable(now_day_o))
    else $error("stalled result changed");

  // No result is left over from before reset.
  assert property (@(posedge clk_i) !rst_ni |=> !out_valid_o)
    else $error("result valid right after reset");

endmodule

bind cron_minute_alarm_matcher_top cmam_checker u_cmam_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_valid_i    (in_valid_i),
  .in_stall_o    (in_stall_o),
  .mode_i        (mode_i),
  .set_year_i    (set_year_i),
  .set_month_i   (set_month_i),
  .set_day_i     (set_day_i),
  .set_hour_i    (set_hour_i),
  .set_minute_i  (set_minute_i),
  .set_weekday_i (set_weekday_i),
  .out_valid_o   (out_valid_o),
  .out_stall_i   (out_stall_i),
  .now_year_o    (now_year_o),
  .now_month_o   (now_month_o),
  .now_day_o     (now_day_o),
  .now_hour_o    (now_hour_o),
  .now_minute_o  (now_minute_o),
  .now_weekday_o (now_weekday_o),
  .match_mask_o  (match_mask_o)
);
